@@ rtl/core/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and controller/datapath interface types for the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int DEF_HEAP_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES = 12;
  localparam int DEF_MAX_BLOCKS   = 4096;
  localparam int ALIGN_BYTES      = 16;
  localparam int MIN_SPLIT_BYTES  = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_REINIT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NULL   = 2'd1,
    STAT_NOFIT  = 2'd2,
    STAT_BADPTR = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_FIND,
    S_FREE,
    S_FIT,
    S_SPLIT_T,
    S_SPLIT_B,
    S_ALLOC_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_ANEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BOOT,
    WR_B_USE,
    WR_T,
    WR_B_SPLIT,
    WR_A_FREE
  } wr_sel_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_CUR,
    SRC_B
  } reply_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       pop;
    wr_sel_t    wr_sel;
    logic       reinit;
    logic       reply;
    reply_src_t reply_src;
    status_t    reply_status;
    logic       reply_copy;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic req_zero;
    logic addr_zero;
    logic hit;
    logic fit;
    logic at_end;
    logic big_enough;
    logic can_split;
  } dp_stat_t;

endpackage

@@ rtl/core/ffha_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: walks the block list and orders the record updates.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::ctl_cmd_t ctl,
  output logic               busy
);

  ffha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ffha_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_BOOT: state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: begin
        if (start) state_next = ffha_pkg::S_DECODE;
      end
      ffha_pkg::S_DECODE: begin
        if (stat.op == ffha_pkg::OP_REINIT) begin
          state_next = ffha_pkg::S_INIT;
        end else if (stat.op == ffha_pkg::OP_FREE) begin
          state_next = stat.addr_zero ? ffha_pkg::S_IDLE : ffha_pkg::S_FIND;
        end else if (stat.op == ffha_pkg::OP_REALLOC && !stat.addr_zero) begin
          state_next = ffha_pkg::S_FIND;
        end else begin
          state_next = stat.req_zero ? ffha_pkg::S_IDLE : ffha_pkg::S_FIT;
        end
      end
      ffha_pkg::S_INIT: state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_FIND: begin
        if (stat.hit) begin
          if (stat.op == ffha_pkg::OP_FREE || stat.req_zero) begin
            state_next = ffha_pkg::S_FREE;
          end else if (stat.big_enough) begin
            state_next = ffha_pkg::S_IDLE;
          end else begin
            state_next = ffha_pkg::S_FIT;
          end
        end else if (stat.at_end) begin
          state_next = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_FREE: state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_FIT: begin
        if (stat.fit) begin
          state_next = stat.can_split ? ffha_pkg::S_SPLIT_T : ffha_pkg::S_ALLOC_DONE;
        end else if (stat.at_end) begin
          state_next = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_SPLIT_T: state_next = ffha_pkg::S_SPLIT_B;
      ffha_pkg::S_SPLIT_B: state_next = ffha_pkg::S_ALLOC_DONE;
      ffha_pkg::S_ALLOC_DONE: begin
        if (stat.op == ffha_pkg::OP_REALLOC && !stat.addr_zero) begin
          state_next = ffha_pkg::S_FREE;
        end else begin
          state_next = ffha_pkg::S_IDLE;
        end
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ffha_pkg::S_BOOT: begin
        ctl.wr_sel = ffha_pkg::WR_BOOT;
        ctl.reinit = 1'b1;
      end
      ffha_pkg::S_IDLE: begin
        ctl.latch_in = start;
      end
      ffha_pkg::S_DECODE: begin
        if (stat.op == ffha_pkg::OP_FREE && stat.addr_zero) begin
          ctl.reply        = 1'b1;
          ctl.reply_status = ffha_pkg::STAT_NULL;
        end else if ((stat.op == ffha_pkg::OP_ALLOC
                      || (stat.op == ffha_pkg::OP_REALLOC && stat.addr_zero))
                     && stat.req_zero) begin
          ctl.reply        = 1'b1;
          ctl.reply_status = ffha_pkg::STAT_NULL;
        end else if (stat.op != ffha_pkg::OP_REINIT) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = ffha_pkg::RD_HEAD;
        end
      end
      ffha_pkg::S_INIT: begin
        ctl.wr_sel       = ffha_pkg::WR_BOOT;
        ctl.reinit       = 1'b1;
        ctl.reply        = 1'b1;
        ctl.reply_status = ffha_pkg::STAT_OK;
      end
      ffha_pkg::S_FIND: begin
        if (stat.hit) begin
          ctl.cap_a = 1'b1;
          if (stat.op == ffha_pkg::OP_FREE || stat.req_zero) begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = ffha_pkg::RD_NEXT;
          end else if (stat.big_enough) begin
            ctl.reply        = 1'b1;
            ctl.reply_src    = ffha_pkg::SRC_CUR;
            ctl.reply_status = ffha_pkg::STAT_OK;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = ffha_pkg::RD_HEAD;
          end
        end else if (stat.at_end) begin
          ctl.reply        = 1'b1;
          ctl.reply_status = ffha_pkg::STAT_BADPTR;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = ffha_pkg::RD_NEXT;
        end
      end
      ffha_pkg::S_FREE: begin
        ctl.wr_sel = ffha_pkg::WR_A_FREE;
        ctl.reply  = 1'b1;
        if (stat.op == ffha_pkg::OP_FREE) begin
          ctl.reply_status = ffha_pkg::STAT_OK;
        end else if (stat.req_zero) begin
          ctl.reply_status = ffha_pkg::STAT_NULL;
        end else begin
          ctl.reply_src    = ffha_pkg::SRC_B;
          ctl.reply_status = ffha_pkg::STAT_OK;
          ctl.reply_copy   = 1'b1;
        end
      end
      ffha_pkg::S_FIT: begin
        if (stat.fit) begin
          ctl.cap_b = 1'b1;
          if (stat.can_split) begin
            ctl.pop = 1'b1;
          end else begin
            ctl.wr_sel = ffha_pkg::WR_B_USE;
          end
        end else if (stat.at_end) begin
          ctl.reply        = 1'b1;
          ctl.reply_status = ffha_pkg::STAT_NOFIT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = ffha_pkg::RD_NEXT;
        end
      end
      ffha_pkg::S_SPLIT_T: ctl.wr_sel = ffha_pkg::WR_T;
      ffha_pkg::S_SPLIT_B: ctl.wr_sel = ffha_pkg::WR_B_SPLIT;
      ffha_pkg::S_ALLOC_DONE: begin
        if (stat.op == ffha_pkg::OP_REALLOC && !stat.addr_zero) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = ffha_pkg::RD_ANEXT;
        end else begin
          ctl.reply        = 1'b1;
          ctl.reply_src    = ffha_pkg::SRC_B;
          ctl.reply_status = ffha_pkg::STAT_OK;
        end
      end
      default: ctl = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_reply_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.reply |=> (state == ffha_pkg::S_IDLE))
    else $error("reply issued without returning to idle");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_IDLE && !start) |=> (state == ffha_pkg::S_IDLE))
    else $error("left idle without a start");

  a_pop_split: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> (state == ffha_pkg::S_SPLIT_T))
    else $error("spare slot popped outside a split");
`endif

endmodule

@@ rtl/core/ffha_dp.sv @@
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: block record memory, spare slot stack, request and result
// registers.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
  input  logic               clk,
  input  logic               rst,
  input  ffha_pkg::ctl_cmd_t ctl,
  output ffha_pkg::dp_stat_t stat,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         cmd,
  input  logic [16:0]        req_bytes,
  input  logic [31:0]        user_addr,
  output logic               done,
  output logic [31:0]        result_addr,
  output logic [16:0]        granted_bytes,
  output logic [16:0]        copy_bytes,
  output logic [1:0]         status
);

  localparam int SLOT_W = $clog2(MAX_BLOCKS);
  localparam int NEXT_W = SLOT_W + 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int OFF_W  = $clog2(HEAP_BYTES);
  localparam int SZ_W   = ($clog2(HEAP_BYTES + 1) > 18) ? $clog2(HEAP_BYTES + 1) : 18;
  localparam int SPL_W  = SZ_W + 1;
  localparam int REC_W  = OFF_W + SZ_W + 1 + NEXT_W;

  localparam logic [NEXT_W-1:0] LIST_END  = NEXT_W'(MAX_BLOCKS);
  localparam logic [SZ_W-1:0]   HDR       = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]   INIT_SIZE = SZ_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [SPL_W-1:0]  SPLIT_ADD =
    SPL_W'(HEADER_BYTES + ffha_pkg::MIN_SPLIT_BYTES);
  localparam logic [17:0]       ALIGN_M1  = 18'(ffha_pkg::ALIGN_BYTES - 1);

  logic [31:0]       heap_base;
  ffha_pkg::op_t     op;
  logic [16:0]       req_q;
  logic              addr_zero;
  logic [SZ_W-1:0]   need;
  logic [31:0]       target;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] slot_a, slot_b, new_slot;
  logic [OFF_W-1:0]  a_off, b_off;
  logic [SZ_W-1:0]   a_size, b_size;
  logic [NEXT_W-1:0] a_next, b_next;
  logic [CNT_W-1:0]  spare_count, mark;

  logic              rec_wr_en;
  logic [SLOT_W-1:0] rec_wr_addr, rec_rd_addr;
  logic [REC_W-1:0]  rec_wr_data, rec_rd_data;
  logic [SLOT_W-1:0] spare_rd_data, spare_virgin, new_t;

  logic [OFF_W-1:0]  rd_off;
  logic [SZ_W-1:0]   rd_size;
  logic              rd_used;
  logic [NEXT_W-1:0] rd_next;
  logic              merge, push;

  assign rd_off  = rec_rd_data[REC_W-1 -: OFF_W];
  assign rd_size = rec_rd_data[NEXT_W+1 +: SZ_W];
  assign rd_used = rec_rd_data[NEXT_W];
  assign rd_next = rec_rd_data[NEXT_W-1:0];

  assign stat.op         = op;
  assign stat.req_zero   = (req_q == 17'd0);
  assign stat.addr_zero  = addr_zero;
  assign stat.hit        = rd_used && (32'(rd_off) == target);
  assign stat.fit        = !rd_used && (rd_size >= need);
  assign stat.at_end     = (rd_next == LIST_END);
  assign stat.big_enough = (rd_size >= SZ_W'(req_q));
  assign stat.can_split  = (SPL_W'(rd_size) >= SPL_W'(need) + SPLIT_ADD)
                           && (spare_count != '0);

  // Stack entries below the lowest index written since the last reinit
  // still hold their initial contents, a descending run of slot numbers.
  assign spare_virgin = SLOT_W'(MAX_BLOCKS - 1) - spare_count[SLOT_W-1:0];
  assign new_t        = (spare_count < mark) ? spare_virgin : spare_rd_data;

  assign merge = (a_next != LIST_END) && !rd_used;
  assign push  = (ctl.wr_sel == ffha_pkg::WR_A_FREE) && merge
                 && (spare_count != CNT_W'(MAX_BLOCKS));

  always_comb begin
    unique case (ctl.rd_sel)
      ffha_pkg::RD_HEAD:  rec_rd_addr = '0;
      ffha_pkg::RD_NEXT:  rec_rd_addr = rd_next[SLOT_W-1:0];
      ffha_pkg::RD_ANEXT: rec_rd_addr = a_next[SLOT_W-1:0];
      default:            rec_rd_addr = '0;
    endcase
  end

  always_comb begin
    rec_wr_en   = 1'b1;
    rec_wr_addr = '0;
    rec_wr_data = '0;
    unique case (ctl.wr_sel)
      ffha_pkg::WR_NONE: rec_wr_en = 1'b0;
      ffha_pkg::WR_BOOT: begin
        rec_wr_data = {OFF_W'(0), INIT_SIZE, 1'b0, LIST_END};
      end
      ffha_pkg::WR_B_USE: begin
        rec_wr_addr = cur_slot;
        rec_wr_data = {rd_off, rd_size, 1'b1, rd_next};
      end
      ffha_pkg::WR_T: begin
        rec_wr_addr = new_t;
        rec_wr_data = {OFF_W'(SZ_W'(b_off) + HDR + need), b_size - need - HDR,
                       1'b0, b_next};
      end
      ffha_pkg::WR_B_SPLIT: begin
        rec_wr_addr = slot_b;
        rec_wr_data = {b_off, need, 1'b1, NEXT_W'(new_slot)};
      end
      ffha_pkg::WR_A_FREE: begin
        rec_wr_addr = slot_a;
        if (merge) begin
          rec_wr_data = {a_off, a_size + rd_size + HDR, 1'b0, rd_next};
        end else begin
          rec_wr_data = {a_off, a_size, 1'b0, a_next};
        end
      end
      default: rec_wr_en = 1'b0;
    endcase
  end

  ffha_ram #(.WIDTH(REC_W), .DEPTH(MAX_BLOCKS)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (rec_wr_addr),
    .wr_data (rec_wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rec_rd_addr),
    .rd_data (rec_rd_data)
  );

  ffha_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_spare_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (spare_count[SLOT_W-1:0]),
    .wr_data (a_next[SLOT_W-1:0]),
    .rd_en   (ctl.pop),
    .rd_addr (SLOT_W'(spare_count - CNT_W'(1))),
    .rd_data (spare_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= '0;
      spare_count <= CNT_W'(MAX_BLOCKS - 1);
      mark        <= CNT_W'(MAX_BLOCKS);
      done        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        heap_base <= cfg_data;
      end
      if (ctl.reinit) begin
        spare_count <= CNT_W'(MAX_BLOCKS - 1);
        mark        <= CNT_W'(MAX_BLOCKS);
      end else if (ctl.pop) begin
        spare_count <= spare_count - CNT_W'(1);
      end else if (push) begin
        spare_count <= spare_count + CNT_W'(1);
        if (spare_count < mark) begin
          mark <= spare_count;
        end
      end
      done <= ctl.reply;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      op        <= ffha_pkg::op_t'(cmd);
      req_q     <= req_bytes;
      addr_zero <= (user_addr == 32'd0);
      need      <= SZ_W'((18'(req_bytes) + ALIGN_M1) & ~ALIGN_M1);
      target    <= user_addr - heap_base - 32'(HEADER_BYTES);
    end
    if (ctl.rd_en) begin
      cur_slot <= rec_rd_addr;
    end
    if (ctl.cap_a) begin
      slot_a <= cur_slot;
      a_off  <= rd_off;
      a_size <= rd_size;
      a_next <= rd_next;
    end
    if (ctl.cap_b) begin
      slot_b <= cur_slot;
      b_off  <= rd_off;
      b_size <= rd_size;
      b_next <= rd_next;
    end
    if (ctl.wr_sel == ffha_pkg::WR_T) begin
      new_slot <= new_t;
    end
    if (ctl.wr_sel == ffha_pkg::WR_B_SPLIT) begin
      b_size <= need;
    end
    if (ctl.reply) begin
      status <= ctl.reply_status;
      unique case (ctl.reply_src)
        ffha_pkg::SRC_CUR: begin
          result_addr   <= heap_base + 32'(rd_off) + 32'(HEADER_BYTES);
          granted_bytes <= 17'(rd_size);
        end
        ffha_pkg::SRC_B: begin
          result_addr   <= heap_base + 32'(b_off) + 32'(HEADER_BYTES);
          granted_bytes <= 17'(b_size);
        end
        default: begin
          result_addr   <= '0;
          granted_bytes <= '0;
        end
      endcase
      copy_bytes <= ctl.reply_copy ? 17'(a_size) : 17'd0;
    end
  end

endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered list of headed blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. Every request
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall, so it must capture the result in that cycle. The
// block list lives in a memory and is walked one record per clock, so the
// list position of the sought block sets the time, and a moving reallocate
// pays for both walks. Results appear on the cycle after the last step,
// and busy drops in that same cycle. After reset the block is busy for one
// cycle while the first list record is written; no memory clearing pass is
// needed. The heap base register may be written at any time the block is
// idle; its ready is always high.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [16:0] req_bytes,
  input  logic [31:0] user_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] result_addr,
  output logic [16:0] granted_bytes,
  output logic [16:0] copy_bytes,
  output logic [1:0]  status
);

  ffha_pkg::ctl_cmd_t ctl;
  ffha_pkg::dp_stat_t stat;

  // The heap base register takes a transfer on any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences list walks, splits and merges.
  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // The datapath holds the record memory, the spare slot stack and results.
  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .req_bytes     (req_bytes),
    .user_addr     (user_addr),
    .done          (done),
    .result_addr   (result_addr),
    .granted_bytes (granted_bytes),
    .copy_bytes    (copy_bytes),
    .status        (status)
  );

endmodule

@@ tb/ffha_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the request, heap base and result channels of the first-fit heap
// allocator, keeps its own copy of the block list to predict every result,
// and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ffha_checker
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd,
  input  logic [16:0] req_bytes,
  input  logic [31:0] user_addr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [31:0] result_addr,
  input  logic [16:0] granted_bytes,
  input  logic [16:0] copy_bytes,
  input  logic [1:0]  status,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int unsigned SLOTS   = DEF_MAX_BLOCKS;
  localparam int unsigned HDR     = DEF_HEADER_BYTES;
  localparam int unsigned NO_SLOT = DEF_MAX_BLOCKS;

  typedef struct {
    logic [31:0] addr;
    logic [16:0] granted;
    logic [16:0] copy;
    logic [1:0]  st;
  } heap_reply_t;

  heap_reply_t replies_due[$];

  // Shadow copy of the block list.
  logic [31:0] heap_base;
  int unsigned blk_off   [SLOTS];
  int unsigned blk_len   [SLOTS];
  bit          blk_taken [SLOTS];
  int unsigned blk_link  [SLOTS];
  int unsigned spare_stk [SLOTS];
  int unsigned spare_top;

  function automatic void list_reset();
    for (int i = 0; i < SLOTS; i++) begin
      blk_off[i] = 0;
      blk_len[i] = 0;
      blk_taken[i] = 0;
      blk_link[i] = 0;
      spare_stk[i] = 0;
    end
    blk_len[0] = DEF_HEAP_BYTES - HDR;
    blk_link[0] = NO_SLOT;
    spare_top = SLOTS - 1;
    for (int i = 0; i < SLOTS - 1; i++) spare_stk[i] = SLOTS - 1 - i;
  endfunction

  function automatic logic [31:0] usable_addr(int unsigned s);
    return heap_base + blk_off[s] + HDR;
  endfunction

  function automatic int unsigned lookup_taken(logic [31:0] a);
    int unsigned s;
    s = 0;
    for (int n = 0; n < SLOTS && s < NO_SLOT; n++) begin
      if (blk_taken[s] && usable_addr(s) == a) return s;
      s = blk_link[s];
    end
    return NO_SLOT;
  endfunction

  function automatic int unsigned take_first_fit(int unsigned req);
    int unsigned need, s, t, n;
    need = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    s = 0;
    for (n = 0; n < SLOTS && s < NO_SLOT; n++) begin
      if (!blk_taken[s] && blk_len[s] >= need) break;
      s = blk_link[s];
    end
    if (s >= NO_SLOT || n >= SLOTS) return NO_SLOT;
    // Split off the tail when it can carry a header plus a minimum area.
    if (blk_len[s] >= need + HDR + MIN_SPLIT_BYTES && spare_top > 0) begin
      spare_top--;
      t = spare_stk[spare_top] % SLOTS;
      blk_off[t] = blk_off[s] + HDR + need;
      blk_len[t] = blk_len[s] - need - HDR;
      blk_taken[t] = 0;
      blk_link[t] = blk_link[s];
      blk_len[s] = need;
      blk_link[s] = t;
    end
    blk_taken[s] = 1;
    return s;
  endfunction

  // Releasing a block merges it only with its successor.
  function automatic void release_block(int unsigned s);
    int unsigned t;
    t = blk_link[s];
    blk_taken[s] = 0;
    if (t < NO_SLOT && !blk_taken[t]) begin
      blk_len[s] = blk_len[s] + blk_len[t] + HDR;
      blk_link[s] = blk_link[t];
      if (spare_top < SLOTS) begin
        spare_stk[spare_top] = t;
        spare_top++;
      end
    end
  endfunction

  function automatic heap_reply_t reply_of(logic [31:0] a, int unsigned g, int unsigned c,
                                           logic [1:0] st);
    heap_reply_t r;
    r.addr = a;
    r.granted = g[16:0];
    r.copy = c[16:0];
    r.st = st;
    return r;
  endfunction

  function automatic heap_reply_t predict_reply(logic [1:0] op, int unsigned req,
                                                logic [31:0] a);
    int unsigned s, t, old_len;
    if (op == OP_REINIT) begin
      list_reset();
      return reply_of(0, 0, 0, STAT_OK);
    end
    if (op == OP_FREE) begin
      if (a == 0) return reply_of(0, 0, 0, STAT_NULL);
      s = lookup_taken(a);
      if (s >= NO_SLOT) return reply_of(0, 0, 0, STAT_BADPTR);
      release_block(s);
      return reply_of(0, 0, 0, STAT_OK);
    end
    if (op == OP_REALLOC && a != 0) begin
      s = lookup_taken(a);
      if (s >= NO_SLOT) return reply_of(0, 0, 0, STAT_BADPTR);
      if (req == 0) begin
        release_block(s);
        return reply_of(0, 0, 0, STAT_NULL);
      end
      // Kept in place when the current area already holds the raw request.
      if (blk_len[s] >= req) return reply_of(usable_addr(s), blk_len[s], 0, STAT_OK);
      t = take_first_fit(req);
      if (t >= NO_SLOT) return reply_of(0, 0, 0, STAT_NOFIT);
      old_len = blk_len[s];
      release_block(s);
      return reply_of(usable_addr(t), blk_len[t], old_len, STAT_OK);
    end
    if (req == 0) return reply_of(0, 0, 0, STAT_NULL);
    t = take_first_fit(req);
    if (t >= NO_SLOT) return reply_of(0, 0, 0, STAT_NOFIT);
    return reply_of(usable_addr(t), blk_len[t], 0, STAT_OK);
  endfunction

  always @(posedge clk) begin
    heap_reply_t due;
    if (rst) begin
      heap_base = 0;
      list_reset();
      replies_due.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          due = replies_due.pop_front();
          checked <= checked + 1;
          if (result_addr !== due.addr || granted_bytes !== due.granted ||
              copy_bytes !== due.copy || status !== due.st)
            errors <= errors + 1;
          if (result_addr !== due.addr)
            $error("result_addr expected %h got %h", due.addr, result_addr);
          if (granted_bytes !== due.granted)
            $error("granted_bytes expected %0d got %0d", due.granted, granted_bytes);
          if (copy_bytes !== due.copy)
            $error("copy_bytes expected %0d got %0d", due.copy, copy_bytes);
          if (status !== due.st)
            $error("status expected %0d got %0d", due.st, status);
        end
      end
      if (cfg_valid && cfg_ready) heap_base = cfg_data;
      if (start && !busy) replies_due.push_back(predict_reply(cmd, req_bytes, user_addr));
    end
    pending <= replies_due.size();
  end

endmodule

@@ tb/tb_first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives the first-fit heap allocator with a directed set of corner requests
// and then random phases of allocate, free and reallocate traffic under
// several heap base settings; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [16:0] req_bytes;
  logic [31:0] user_addr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        done;
  logic [31:0] result_addr;
  logic [16:0] granted_bytes;
  logic [16:0] copy_bytes;
  logic [1:0]  status;
  int          errors;
  int          pending;
  int          checked;

  // Pointers handed out by the block, used to build well-formed frees and
  // reallocates. Entries may go stale; a stale pointer is just another
  // unknown-pointer case.
  logic [31:0] live_ptrs[$];
  logic [31:0] last_addr;
  int          sent;
  int          base_writes;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .req_bytes(req_bytes), .user_addr(user_addr), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .result_addr(result_addr), .granted_bytes(granted_bytes),
    .copy_bytes(copy_bytes), .status(status)
  );

  ffha_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .req_bytes(req_bytes), .user_addr(user_addr), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .result_addr(result_addr), .granted_bytes(granted_bytes),
    .copy_bytes(copy_bytes), .status(status), .errors(errors),
    .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Collect every pointer that a successful allocate or reallocate returns.
  always @(posedge clk) begin
    if (done) begin
      last_addr <= result_addr;
      if (status == STAT_OK && result_addr != 0) live_ptrs.push_back(result_addr);
    end
  end

  // Presents one request and holds it until the block takes the transfer.
  // Start is left high so that a following request in the same burst is
  // back to back; the caller lowers it when a gap follows.
  task automatic send(logic [1:0] c, int unsigned r, logic [31:0] a);
    start <= 1'b1;
    cmd <= c;
    req_bytes <= r[16:0];
    user_addr <= a;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Waits until every predicted result has come back.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A directed request: sent on its own and waited out so that the next one
  // can reuse the pointer it returned.
  task automatic one(logic [1:0] c, int unsigned r, logic [31:0] a);
    send(c, r, a);
    start <= 1'b0;
    drain();
    @(posedge clk);
  endtask

  // The heap base is changed only with the block idle. Old pointers become
  // meaningless after a change, so the pool is dropped.
  task automatic write_base(logic [31:0] v);
    drain();
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_writes++;
    live_ptrs.delete();
  endtask

  function automatic logic [31:0] pick_ptr(bit take);
    int idx;
    logic [31:0] p;
    if (live_ptrs.size() == 0) return $urandom();
    idx = $urandom_range(0, live_ptrs.size() - 1);
    p = live_ptrs[idx];
    if (take) live_ptrs.delete(idx);
    return p;
  endfunction

  // One random request. Most of the traffic is allocate, free and
  // reallocate of live pointers; the rest is null, zero size, unknown
  // pointers, oversized requests and the odd reinitialize.
  task automatic random_request();
    int unsigned roll, sz;
    roll = $urandom_range(0, 99);
    sz = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 300);
    if (roll < 38) send(OP_ALLOC, sz, $urandom());
    else if (roll < 63) send(OP_FREE, 0, pick_ptr(1));
    else if (roll < 78) send(OP_REALLOC, sz, pick_ptr(1));
    else if (roll < 82) send(OP_REALLOC, sz, 0);
    else if (roll < 85) send(OP_REALLOC, 0, pick_ptr(1));
    else if (roll < 87) send(OP_ALLOC, 0, 0);
    else if (roll < 89) send(OP_FREE, $urandom_range(0, 65536), 0);
    else if (roll < 97) send($urandom_range(0, 2), $urandom_range(0, 131071), $urandom());
    else begin
      send(OP_REINIT, $urandom_range(0, 131071), $urandom());
      live_ptrs.delete();
    end
  endtask

  // A phase of random traffic in bursts with random gaps. Some phases run
  // with no gaps at all.
  task automatic random_phase(int count, bit gapless);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && left > 0; i++) begin
        random_request();
        left--;
      end
      if (!gapless && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [31:0] p, q;
    rst = 1'b1;
    start = 1'b0;
    cmd = OP_ALLOC;
    req_bytes = '0;
    user_addr = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sent = 0;
    base_writes = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed corners with the heap at address zero.
    write_base(32'h0);
    one(OP_ALLOC, 0, 0);              // zero size
    one(OP_ALLOC, 65536, 0);          // larger than the heap
    one(OP_ALLOC, 65524, 0);          // rounds past the only block
    one(OP_ALLOC, 65520, 0);          // whole heap, tail too small to split
    p = last_addr;
    one(OP_FREE, 0, p);
    one(OP_FREE, 0, p);               // second free of the same block
    one(OP_FREE, 0, 0);               // null free
    one(OP_FREE, 0, 32'hFFFF_FFFF);   // unknown pointer
    one(OP_ALLOC, 1, 0);
    p = last_addr;
    one(OP_REALLOC, 16, p);           // already large enough
    one(OP_ALLOC, 40, 0);
    q = last_addr;
    one(OP_REALLOC, 500, p);          // moves and reports a copy
    p = last_addr;
    one(OP_REALLOC, 65536, p);        // move that cannot fit
    one(OP_REALLOC, 0, q);            // zero size frees
    one(OP_REALLOC, 0, q);            // zero size on a stale pointer
    one(OP_REALLOC, 5, 0);            // null behaves as allocate
    one(OP_REALLOC, 7, 32'h8000_0001);
    one(OP_REINIT, 0, 0);
    one(OP_ALLOC, 65536, 32'hFFFF_FFFF);
    live_ptrs.delete();

    // Random phases, each under a different heap base, extremes included.
    random_phase(100, 0);
    write_base(32'hFFFF_FFF0);        // addresses wrap around zero
    random_phase(100, 1);
    write_base($urandom());
    random_phase(100, 0);
    write_base(32'hFFFF_FFFF);
    random_phase(100, 0);
    write_base(32'h8000_0000);
    random_phase(100, 0);

    drain();
    repeat (20) @(posedge clk);
    $display("Summary: %0d requests sent, %0d results checked, %0d heap base writes.",
             sent, checked, base_writes);
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Far beyond the slowest legal run: every request walking a full list.
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
